// ----- rtl/core/cgjf_pkg.sv -----
// Shared types and constants for the credit gated job queue.
// Used by credit_gated_job_fifo_unit; depends on nothing.
package cgjf_pkg;

  localparam int unsigned DefStoreDepth = 16;
  localparam int unsigned DocW          = 32;
  localparam int unsigned CapW          = 5;
  localparam int unsigned CreditW       = 32;
  localparam int unsigned HeldW         = 5;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  // Register byte addresses on the configuration port.
  localparam logic [ApbAddrW-1:0] RegQueueCapacity = 3'd0;
  localparam logic [ApbAddrW-1:0] RegInitialCredit = 3'd4;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_REFILL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NO_CREDIT = 2'd3
  } status_e;

endpackage

// ----- rtl/core/cgjf_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; instanced by credit_gated_job_fifo_unit for the job store.
module cgjf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/credit_gated_job_fifo_unit.sv -----
// Credit gated job queue: a bounded ring of document words whose removals use up credit.
// Depends on cgjf_pkg and cgjf_ram.
//
// Usage: each request on the slave stream carries an operation in tuser (add, remove,
// refill) and a 32-bit word in tdata. Every request yields exactly one result on the
// master stream: status in tuser, the removed word and the held count in tdata.
// The APB port sets the capacity (address 0) and the initial credit (address 4);
// writing the initial credit also loads the credit counter. Write it only while idle.
// A request accepted at an edge is shown in the cycle after it. All
// decisions are made from the count, capacity and credit at the accepting edge; the
// store is read through the RAM's registered port, which holds the word for the result.
// Throughput is one request per cycle as long as the receiver takes results, since
// s_axis_tready is high whenever the result register is empty or being drained.
// When the receiver stalls, the result holds and no new request is taken.
// Reset clears pointers, count, credit and the output valid; capacity returns to 16.
// The store itself is not cleared: only words that were added are ever read.
module credit_gated_job_fifo_unit
  import cgjf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = DefStoreDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // [31:0] value
  input  logic [1:0]          s_axis_tuser,   // [1:0] operation
  // Result stream.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // [31:0] document_out, [36:32] held_count
  output logic [1:0]          m_axis_tuser,   // [1:0] status
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned PtrW = $clog2(STORE_DEPTH);
  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;
  localparam logic [PtrW-1:0] LastPtr   = PtrW'(STORE_DEPTH - 1);
  localparam logic [CmpW-1:0] DepthCmp  = CmpW'(STORE_DEPTH);

  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CreditW-1:0] credit_q, credit_d;
  logic [CapW-1:0]    cap_q, cap_d;
  logic [CreditW-1:0] init_credit_q, init_credit_d;

  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic [HeldW-1:0]   held_q, held_d;
  logic               doc_sel_q, doc_sel_d;

  logic               in_fire;
  logic               cfg_write;
  logic               push, pop;
  logic [CmpW-1:0]    cap_cmp, cap_eff;
  logic [DocW-1:0]    ram_rdata;
  op_e                op;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_write     = psel && penable && pwrite;
  assign op            = op_e'(s_axis_tuser);

  assign cap_cmp = CmpW'(cap_q);
  assign cap_eff = (cap_cmp > DepthCmp) ? DepthCmp : cap_cmp;

  always_comb begin
    push          = 1'b0;
    pop           = 1'b0;
    status_d      = ST_OK;
    credit_d      = credit_q;
    cap_d         = cap_q;
    init_credit_d = init_credit_q;

    if (in_fire) begin
      unique case (op)
        OP_ADD: begin
          if (CmpW'(count_q) >= cap_eff) begin
            status_d = ST_FULL;
          end else begin
            push = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else if (credit_q == '0) begin
            status_d = ST_NO_CREDIT;
          end else begin
            pop      = 1'b1;
            credit_d = credit_q - CreditW'(1);
          end
        end
        OP_REFILL: begin
          credit_d = s_axis_tdata;
        end
        default: begin
        end
      endcase
    end

    // The user must make configuration writes only while the queue is idle; the block does not enforce it.
    if (cfg_write) begin
      unique case (paddr)
        RegQueueCapacity: cap_d = pwdata[CapW-1:0];
        RegInitialCredit: begin
          init_credit_d = pwdata;
          credit_d      = pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      count_d  = count_q + CntW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      count_d  = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    held_d      = held_q;
    doc_sel_d   = doc_sel_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
      held_d      = HeldW'(count_d);
      doc_sel_d   = pop;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q      <= '0;
      wr_ptr_q      <= '0;
      count_q       <= '0;
      credit_q      <= '0;
      cap_q         <= CapReset;
      init_credit_q <= '0;
      out_valid_q   <= 1'b0;
      held_q        <= '0;
      doc_sel_q     <= 1'b0;
      status_q      <= ST_OK;
    end else begin
      rd_ptr_q      <= rd_ptr_d;
      wr_ptr_q      <= wr_ptr_d;
      count_q       <= count_d;
      credit_q      <= credit_d;
      cap_q         <= cap_d;
      init_credit_q <= init_credit_d;
      out_valid_q   <= out_valid_d;
      held_q        <= held_d;
      doc_sel_q     <= doc_sel_d;
      if (in_fire) begin
        status_q <= status_d;
      end
    end
  end

  // A word is only read after the edge that wrote it, so no bypass is needed.
  cgjf_ram #(
    .WIDTH (DocW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (wr_ptr_q),
    .wdata_i (s_axis_tdata),
    .re_i    (pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {3'b000, held_q, (doc_sel_q ? ram_rdata : {DocW{1'b0}})};

  always_comb begin
    unique case (paddr)
      RegQueueCapacity: prdata = ApbDataW'(cap_q);
      RegInitialCredit: prdata = init_credit_q;
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

endmodule
